>>> rtl/rgb4dith_pkg.sv
package rgb4dith_pkg;

	// configuration port
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 11;
	localparam int FRAME_WIDTH_W  = 10;
	localparam int FRAME_HEIGHT_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_DITHER_ENABLE = 2'd2
	} cfg_reg_t;

	localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 10'd512;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 11'd512;
	localparam logic                      DITHER_RST       = 1'b1;

	// pixel format
	localparam int PIXEL_W = 16;
	localparam int COLOR_W = 2;

	typedef enum logic [COLOR_W-1:0] {
		COLOR_BLACK  = 2'd0,
		COLOR_WHITE  = 2'd1,
		COLOR_YELLOW = 2'd2,
		COLOR_RED    = 2'd3
	} color_t;

	// palette channel levels
	localparam logic [7:0] CH_FULL = 8'hff;
	localparam logic [7:0] CH_NONE = 8'h00;

	// nearest-color decision thresholds (squared distances reduce to linear tests)
	localparam int TH_HALF  = 128;  // one channel at or above mid level
	localparam int TH_LOW   = 127;  // one channel at or below mid level
	localparam int TH_PAIR  = 256;  // two channels summed, strictly above 255
	localparam int TH_PAIRL = 254;  // two channels summed, strictly below 255
	localparam int TH_TRIO  = 383;  // three channels summed, strictly above 382.5

endpackage

>>> rtl/rgb565_four_color_dither_top.sv
// Channel    | Direction | Handshake                   | Payload
// pixel      | in        | pixel_valid / pixel_ready   | pixel_rgb565
// result     | out       | result_valid / result_ready | color_index, end_of_row, end_of_frame
// config     | in        | cfg_we (no wait)            | cfg_index, cfg_data
//
// One pixel per cycle sustained while results are taken; a result reaches result_valid
// through the output register. The serial path is the right-neighbor carry loop in stage 1
// (add, nearest color, error, 7/16 share); the line store has one write port, the
// last-column write of each row goes out in the following cycle.
// Reset clears counters, carry and pending sums; the line store is not swept:
// entries at or above the written high-water mark read as zero.
// result_ready low holds stage 1 and then drops pixel_ready.
module rgb565_four_color_dither_top #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 1024,
	parameter int ACC_BITS   = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rgb4dith_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rgb4dith_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                  pixel_valid,
	output logic                                  pixel_ready,
	input  logic [rgb4dith_pkg::PIXEL_W-1:0]      pixel_rgb565,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic [rgb4dith_pkg::COLOR_W-1:0]      color_index,
	output logic                                  end_of_row,
	output logic                                  end_of_frame
);
	import rgb4dith_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int FW = $clog2(MAX_WIDTH + 1);
	localparam int A  = ACC_BITS;
	localparam int SW = ACC_BITS + 2;
	localparam int EW = 3 * ACC_BITS;

	localparam logic signed [SW-1:0] T_HALF  = SW'(TH_HALF);
	localparam logic signed [SW-1:0] T_LOW   = SW'(TH_LOW);
	localparam logic signed [SW-1:0] T_PAIR  = SW'(TH_PAIR);
	localparam logic signed [SW-1:0] T_PAIRL = SW'(TH_PAIRL);
	localparam logic signed [SW-1:0] T_TRIO  = SW'(TH_TRIO);
	localparam logic signed [A-1:0]  ACC_MAX = {1'b0, {(A-1){1'b1}}};
	localparam logic signed [A-1:0]  ACC_MIN = {1'b1, {(A-1){1'b0}}};

	function automatic logic signed [A-1:0] sat_acc(input logic signed [SW-1:0] x);
		logic signed [A-1:0] r;
		if (x > SW'(ACC_MAX))
			r = ACC_MAX;
		else if (x < SW'(ACC_MIN))
			r = ACC_MIN;
		else
			r = x[A-1:0];
		return r;
	endfunction

	// configuration registers
	logic [FRAME_WIDTH_W-1:0]  width_q;
	logic [FRAME_HEIGHT_W-1:0] height_q;
	logic                      dither_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
			dither_q <= DITHER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:   width_q  <= cfg_data[FRAME_WIDTH_W-1:0];
				REG_FRAME_HEIGHT:  height_q <= cfg_data[FRAME_HEIGHT_W-1:0];
				REG_DITHER_ENABLE: dither_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake and stage control
	logic valid_s1;
	logic s1_move;
	logic accept;
	logic result_valid_q;

	assign s1_move     = valid_s1 && (!result_valid_q || result_ready);
	assign pixel_ready = !valid_s1 || s1_move;
	assign accept      = pixel_valid && pixel_ready;

	// raster position
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;
	logic          last_col_c;
	logic          last_row_c;

	assign col_inc    = {1'b0, col_q} + 1'b1;
	assign row_inc    = {1'b0, row_q} + 1'b1;
	assign last_col_c = (width_q == '0) || (32'(col_inc) >= 32'(width_q))
		|| (32'(col_inc) == 32'(MAX_WIDTH));
	assign last_row_c = (height_q == '0) || (32'(row_inc) >= 32'(height_q))
		|| (32'(row_inc) == 32'(MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col_c) begin
				col_q <= '0;
				row_q <= last_row_c ? '0 : row_inc[RW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// line store write port (left neighbor or deferred last-column entry)
	logic          left_wr;
	logic          wr_en;
	logic [CW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic          tail_pend_q;
	logic [CW-1:0] tail_addr_q;
	logic [EW-1:0] tail_data_q;
	logic [EW-1:0] done_left_pk;
	logic [EW-1:0] next_a_pk;
	logic [CW-1:0] x_s1;
	logic          last_col_s1;
	logic          last_row_s1;

	assign left_wr = s1_move && (x_s1 != '0);
	assign wr_en   = left_wr || tail_pend_q;
	assign wr_addr = tail_pend_q ? tail_addr_q : CW'(x_s1 - 1'b1);
	assign wr_data = tail_pend_q ? tail_data_q : done_left_pk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tail_pend_q <= 1'b0;
		else
			tail_pend_q <= s1_move && last_col_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_move && last_col_s1) begin
			tail_addr_q <= x_s1;
			tail_data_q <= next_a_pk;
		end
	end

	// written high-water mark: entries at or above it read as zero
	logic [FW-1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (wr_en && (FW'({1'b0, wr_addr} + 1'b1) > fill_q))
			fill_q <= FW'({1'b0, wr_addr} + 1'b1);
	end

	// line store
	logic [EW-1:0] store_mem [MAX_WIDTH];
	logic [EW-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			store_mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= store_mem[col_q];
	end

	// stage 1 registers
	logic [PIXEL_W-1:0] pix_s1;
	logic               dith_s1;
	logic               zero_s1;
	logic               fwd_hit_s1;
	logic [EW-1:0]      fwd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (s1_move)
			valid_s1 <= 1'b0;
	end

	// catch any store write to the entry in flight, from the read edge until use
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixel_rgb565;
			x_s1        <= col_q;
			last_col_s1 <= last_col_c;
			last_row_s1 <= last_row_c;
			dith_s1     <= dither_q;
			zero_s1     <= FW'(col_q) >= fill_q;
			fwd_hit_s1  <= wr_en && (wr_addr == col_q);
			fwd_data_s1 <= wr_data;
		end else if (valid_s1 && wr_en && (wr_addr == x_s1)) begin
			fwd_hit_s1  <= 1'b1;
			fwd_data_s1 <= wr_data;
		end
	end

	// error state carried along the row
	logic signed [A-1:0] carry_q [3];
	logic signed [A-1:0] pend0_q [3];
	logic signed [A-1:0] pend1_q [3];

	// per-channel datapath
	logic [EW-1:0]       st_pk;
	logic [7:0]          rgb8 [3];
	logic signed [A-1:0] st_ch [3];
	logic signed [A-1:0] v_ch [3];
	logic [7:0]          pal [3];
	logic signed [A:0]   e_ch [3];
	logic signed [A+3:0] ext [3];
	logic signed [A+3:0] m7 [3];
	logic signed [A+3:0] m5 [3];
	logic signed [A+3:0] m3 [3];
	logic signed [A-1:0] s7 [3];
	logic signed [A-1:0] s5 [3];
	logic signed [A-1:0] s3 [3];
	logic signed [A-1:0] s1 [3];
	logic signed [A-1:0] done_left [3];
	logic signed [A-1:0] next_a [3];

	// a one-pixel row reads back the entry its predecessor writes this very cycle
	assign st_pk   = (tail_pend_q && (tail_addr_q == x_s1)) ? tail_data_q
		: (fwd_hit_s1 ? fwd_data_s1 : (zero_s1 ? '0 : rd_s1));
	assign rgb8[0] = {pix_s1[15:11], pix_s1[15:13]};
	assign rgb8[1] = {pix_s1[10:5], pix_s1[10:9]};
	assign rgb8[2] = {pix_s1[4:0], pix_s1[4:2]};

	// working value: widened pixel plus, when dithering, the error pending for this column
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			st_ch[k] = st_pk[k*A +: A];
			if (dith_s1)
				v_ch[k] = sat_acc(SW'({1'b0, rgb8[k]}) + SW'(st_ch[k]) + SW'(carry_q[k]));
			else
				v_ch[k] = A'({1'b0, rgb8[k]});
		end
	end

	// nearest palette entry; pairwise distance tests are linear in the channels
	logic signed [SW-1:0] sum_rg;
	logic signed [SW-1:0] sum_gb;
	logic signed [SW-1:0] sum_rgb;
	logic                 lt10, lt20, lt21, lt30, lt31, lt32;
	color_t               best_a;
	color_t               best_b;
	color_t               best;
	logic                 take2;
	logic                 take3;

	assign sum_rg  = SW'(v_ch[0]) + SW'(v_ch[1]);
	assign sum_gb  = SW'(v_ch[1]) + SW'(v_ch[2]);
	assign sum_rgb = sum_rg + SW'(v_ch[2]);
	assign lt10    = sum_rgb >= T_TRIO;
	assign lt20    = sum_rg >= T_PAIR;
	assign lt30    = SW'(v_ch[0]) >= T_HALF;
	assign lt21    = SW'(v_ch[2]) <= T_LOW;
	assign lt31    = sum_gb <= T_PAIRL;
	assign lt32    = SW'(v_ch[1]) <= T_LOW;

	always_comb begin
		best_a = lt10 ? COLOR_WHITE : COLOR_BLACK;
		take2  = (best_a == COLOR_BLACK) ? lt20 : lt21;
		best_b = take2 ? COLOR_YELLOW : best_a;
		case (best_b)
			COLOR_BLACK:  take3 = lt30;
			COLOR_WHITE:  take3 = lt31;
			default:      take3 = lt32;
		endcase
		best = take3 ? COLOR_RED : best_b;
	end

	always_comb begin
		unique case (best)
			COLOR_BLACK:  begin pal[0] = CH_NONE; pal[1] = CH_NONE; pal[2] = CH_NONE; end
			COLOR_WHITE:  begin pal[0] = CH_FULL; pal[1] = CH_FULL; pal[2] = CH_FULL; end
			COLOR_YELLOW: begin pal[0] = CH_FULL; pal[1] = CH_FULL; pal[2] = CH_NONE; end
			default:      begin pal[0] = CH_FULL; pal[1] = CH_NONE; pal[2] = CH_NONE; end
		endcase
	end

	// quantization error and the four floor(err*k/16) shares
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			e_ch[k] = dith_s1 ? ((A+1)'(v_ch[k]) - (A+1)'({1'b0, pal[k]})) : '0;
			ext[k]  = (A+4)'(e_ch[k]);
			m7[k]   = (ext[k] <<< 3) - ext[k];
			m5[k]   = (ext[k] <<< 2) + ext[k];
			m3[k]   = (ext[k] <<< 1) + ext[k];
			s7[k]   = last_col_s1 ? '0 : m7[k][A+3:4];
			s5[k]   = last_row_s1 ? '0 : m5[k][A+3:4];
			s3[k]   = last_row_s1 ? '0 : m3[k][A+3:4];
			s1[k]   = (last_row_s1 || last_col_s1) ? '0 : ext[k][A+3:4];
			done_left[k] = sat_acc(SW'(pend0_q[k]) + SW'(s3[k]));
			next_a[k]    = sat_acc(SW'(pend1_q[k]) + SW'(s5[k]));
		end
	end

	assign done_left_pk = {done_left[2], done_left[1], done_left[0]};
	assign next_a_pk    = {next_a[2], next_a[1], next_a[0]};

	// carry and pending sums commit when the pixel leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				carry_q[k] <= '0;
				pend0_q[k] <= '0;
				pend1_q[k] <= '0;
			end
		end else if (s1_move) begin
			for (int k = 0; k < 3; k++) begin
				if (last_col_s1) begin
					carry_q[k] <= '0;
					pend0_q[k] <= '0;
					pend1_q[k] <= '0;
				end else begin
					carry_q[k] <= s7[k];
					pend0_q[k] <= next_a[k];
					pend1_q[k] <= s1[k];
				end
			end
		end
	end

	// output register
	color_t result_color_q;
	logic   result_eor_q;
	logic   result_eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (s1_move)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			result_color_q <= best;
			result_eor_q   <= last_col_s1;
			result_eof_q   <= last_col_s1 && last_row_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign color_index  = result_color_q;
	assign end_of_row   = result_eor_q;
	assign end_of_frame = result_eof_q;

	// checks
	a_single_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(tail_pend_q && left_wr))
		else $error("line store written by two sources in one cycle");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_col_c && last_row_c |=> (col_q == '0) && (row_q == '0))
		else $error("raster position did not wrap at frame end");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_WIDTH))
		else $error("line store high-water mark beyond depth");

	a_tail_then_col0: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && last_col_s1 |=> !valid_s1 || (x_s1 == '0))
		else $error("pixel after a row end is not at column zero");

endmodule
